>>> hdl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared widths, register indexes, opcodes, state encoding and the
// command / status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package modexp_pkg;

	localparam int WIDTH   = 16;
	localparam int CNT_W   = $clog2(WIDTH);
	localparam int CFG_W   = 1;

	// configuration register indexes
	localparam logic [CFG_W-1:0] CFG_MODULUS  = 1'b0;
	localparam logic [CFG_W-1:0] CFG_EXPONENT = 1'b1;

	// configuration reset values
	localparam logic [WIDTH-1:0] MODULUS_RST  = WIDTH'(2);
	localparam logic [WIDTH-1:0] EXPONENT_RST = WIDTH'(1);

	// modular multiply operation selects
	typedef enum logic [1:0] {
		OP_REDUCE,
		OP_SQUARE,
		OP_MULT
	} mul_op_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SQ_INIT,
		ST_SQUARE,
		ST_MU_INIT,
		ST_MULT,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    mul_init;
		logic    mul_step;
		mul_op_t op;
		logic    ebit_dec;
		logic    emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mod_small;
		logic mul_last;
		logic exp_bit;
		logic ebit_zero;
	} status_t;

endpackage

>>> hdl/modexp_ctrl.sv
// ----------------------------------------------------------------------------
// modexp_ctrl
// Sequencer for left-to-right square-and-multiply: one base reduction,
// then a square and an optional multiply per exponent bit; a modulus below 2 skips all.
// ----------------------------------------------------------------------------
module modexp_ctrl
	import modexp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = status.mod_small ? ST_DONE : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (status.mul_last) begin
					state_d = ST_SQ_INIT;
				end
			end
			ST_SQ_INIT: begin
				state_d = ST_SQUARE;
			end
			ST_SQUARE: begin
				if (status.mul_last) begin
					if (status.exp_bit) begin
						state_d = ST_MU_INIT;
					end else if (status.ebit_zero) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SQ_INIT;
					end
				end
			end
			ST_MU_INIT: begin
				state_d = ST_MULT;
			end
			ST_MULT: begin
				if (status.mul_last) begin
					state_d = status.ebit_zero ? ST_DONE : ST_SQ_INIT;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		cmd.op   = OP_REDUCE;
		busy     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy         = 1'b0;
				cmd.load     = start;
				cmd.mul_init = start && !status.mod_small;
				cmd.op       = OP_REDUCE;
			end
			ST_REDUCE: begin
				cmd.mul_step = 1'b1;
			end
			ST_SQ_INIT: begin
				cmd.mul_init = 1'b1;
				cmd.op       = OP_SQUARE;
			end
			ST_SQUARE: begin
				cmd.mul_step = 1'b1;
				cmd.ebit_dec = status.mul_last && !status.exp_bit && !status.ebit_zero;
			end
			ST_MU_INIT: begin
				cmd.mul_init = 1'b1;
				cmd.op       = OP_MULT;
			end
			ST_MULT: begin
				cmd.mul_step = 1'b1;
				cmd.ebit_dec = status.mul_last && !status.ebit_zero;
			end
			ST_DONE: begin
				cmd.emit = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

>>> hdl/modexp_dp.sv
// ----------------------------------------------------------------------------
// modexp_dp
// Configuration registers, bit-serial modular multiplier (one multiplier
// bit per cycle, double then conditional add), running value and output.
// ----------------------------------------------------------------------------
module modexp_dp
	import modexp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_index,
	input  logic [WIDTH-1:0] cfg_data,
	input  logic [WIDTH-1:0] base,
	input  cmd_t             cmd,
	output status_t          status,
	output logic             done,
	output logic [WIDTH-1:0] result
);

	logic [WIDTH-1:0] modulus_q;
	logic [WIDTH-1:0] exponent_q;
	logic [WIDTH-1:0] bred_q;
	logic [WIDTH-1:0] r_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] mb_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] ebit_q;
	mul_op_t          op_q;
	logic             zero_q;
	logic             done_q;
	logic [WIDTH-1:0] result_q;

	logic [WIDTH:0]   dbl;
	logic [WIDTH-1:0] dbl_red;
	logic [WIDTH:0]   sum;
	logic [WIDTH-1:0] sum_red;
	logic [WIDTH-1:0] acc_d;
	logic             mul_last;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= MODULUS_RST;
			exponent_q <= EXPONENT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODULUS:  modulus_q  <= cfg_data;
				CFG_EXPONENT: exponent_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// one multiplier bit: acc = 2*acc mod m, then + a mod m when the bit is set
	always_comb begin
		dbl     = {acc_q, 1'b0};
		dbl_red = (dbl >= {1'b0, modulus_q}) ? WIDTH'(dbl - {1'b0, modulus_q})
		                                     : dbl[WIDTH-1:0];
		sum     = {1'b0, dbl_red} + {1'b0, a_q};
		sum_red = (sum >= {1'b0, modulus_q}) ? WIDTH'(sum - {1'b0, modulus_q})
		                                     : sum[WIDTH-1:0];
		acc_d   = mb_q[WIDTH-1] ? sum_red : dbl_red;
	end

	assign mul_last = (cnt_q == CNT_W'(WIDTH - 1));

	// multiplier operand load and step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			op_q  <= OP_REDUCE;
		end else if (cmd.mul_init) begin
			cnt_q <= '0;
			op_q  <= cmd.op;
		end else if (cmd.mul_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_init) begin
			acc_q <= '0;
			case (cmd.op)
				OP_REDUCE: begin
					a_q  <= WIDTH'(1);
					mb_q <= base;
				end
				OP_SQUARE: begin
					a_q  <= r_q;
					mb_q <= r_q;
				end
				OP_MULT: begin
					a_q  <= r_q;
					mb_q <= bred_q;
				end
				default: begin
					a_q  <= r_q;
					mb_q <= r_q;
				end
			endcase
		end else if (cmd.mul_step) begin
			acc_q <= acc_d;
			mb_q  <= {mb_q[WIDTH-2:0], 1'b0};
		end
	end

	// running value and reduced base
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_q <= WIDTH'(1);
		end else if (cmd.mul_step && mul_last && op_q != OP_REDUCE) begin
			r_q <= acc_d;
		end
		if (cmd.mul_step && mul_last && op_q == OP_REDUCE) begin
			bred_q <= acc_d;
		end
		if (cmd.load) begin
			zero_q <= (modulus_q < WIDTH'(2));
		end
	end

	// exponent bit pointer, msb first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ebit_q <= '0;
		end else if (cmd.load) begin
			ebit_q <= CNT_W'(WIDTH - 1);
		end else if (cmd.ebit_dec) begin
			ebit_q <= ebit_q - 1'b1;
		end
	end

	// result register and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q <= zero_q ? '0 : r_q;
		end
	end

	assign status.mod_small = (modulus_q < WIDTH'(2));
	assign status.mul_last  = mul_last;
	assign status.exp_bit   = exponent_q[ebit_q];
	assign status.ebit_zero = (ebit_q == '0);

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> hdl/modular_exponentiation.sv
// The sequencer drives a bit-serial modular multiplier, one multiplier bit per cycle.
// A modulus below 2 skips the multiplier and yields result 0.
// A new start can be taken in the cycle of the previous item's done strobe.
// Reset clears the sequencer and loads modulus 2 and exponent 1.
// The done strobe lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base^exponent mod modulus with square-and-multiply, one result
// per start, using a sequencer and a shared modular multiplier datapath.
// ----------------------------------------------------------------------------
module modular_exponentiation
	import modexp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_index,
	input  logic [WIDTH-1:0] cfg_data,
	input  logic             start,
	output logic             busy,
	input  logic [WIDTH-1:0] base,
	output logic             done,
	output logic [WIDTH-1:0] result
);

	cmd_t    cmd;
	status_t status;

	// sequencer
	modexp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// arithmetic and registers
	modexp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.base      (base),
		.cmd       (cmd),
		.status    (status),
		.done      (done),
		.result    (result)
	);

endmodule
